@@ hw/rtl/grapheme_to_phoneme_mapper_defines.svh @@
// assertion macros shared by the phoneme mapper modules
`ifndef GRAPHEME_TO_PHONEME_MAPPER_DEFINES_SVH
`define GRAPHEME_TO_PHONEME_MAPPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define G2P_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("g2p check failed");

// next-cycle implication, checked outside reset
`define G2P_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("g2p check failed");

`endif

@@ hw/rtl/g2p_pkg.sv @@
// types, letter and token codes, and letter classification for the phoneme mapper
`default_nettype none

package g2p_pkg;

   // cp1257 letters outside ascii
   localparam logic [7:0] CH_I_OG  = 8'hc1;
   localparam logic [7:0] CH_E_DOT = 8'hcb;
   localparam logic [7:0] CH_E_OG  = 8'hc6;
   localparam logic [7:0] CH_A_OG  = 8'hc0;
   localparam logic [7:0] CH_U_OG  = 8'hd8;
   localparam logic [7:0] CH_U_MAC = 8'hdb;
   localparam logic [7:0] CH_C_CAR = 8'hc8;
   localparam logic [7:0] CH_S_CAR = 8'hd0;
   localparam logic [7:0] CH_Z_CAR = 8'hde;

   // token codes
   localparam logic [5:0] TOK_BOUNDARY = 6'd0;
   localparam logic [5:0] TOK_GLIDE_J  = 6'd9;
   localparam logic [5:0] TOK_GLIDE_W  = 6'd10;
   localparam logic [5:0] TOK_CODA_L   = 6'd11;
   localparam logic [5:0] TOK_CODA_M   = 6'd12;
   localparam logic [5:0] TOK_CODA_N   = 6'd13;
   localparam logic [5:0] TOK_CODA_R   = 6'd14;
   localparam logic [5:0] TOK_NONE     = 6'd0;
   localparam logic [5:0] TOK_J_SOFT   = 6'd31;

   localparam int unsigned TOKS_PER_ITEM = 3;

   typedef struct packed {
      logic [5:0] phoneme;
      logic       softened;
      logic       word_done;
   } tok_type;

   // tokens caused by one accepted letter, in order, cnt of them valid
   typedef struct packed {
      tok_type [TOKS_PER_ITEM-1:0] toks;
      logic [1:0]                  cnt;
   } rec_type;

   typedef struct packed {
      logic    hit;
      tok_type tok;
   } dec_type;

   function automatic logic [3:0] vowel_code(input logic [7:0] c);
      case (c)
         "A", CH_A_OG:      return 4'd1;
         "E", CH_E_OG:      return 4'd2;
         CH_E_DOT:          return 4'd3;
         "I":               return 4'd4;
         CH_I_OG, "Y":      return 4'd5;
         "O":               return 4'd6;
         "U":               return 4'd7;
         CH_U_MAC, CH_U_OG: return 4'd8;
         default:           return 4'd0;
      endcase
   endfunction

   function automatic logic front_vowel(input logic [7:0] c);
      return c == "I" || c == "Y" || c == CH_I_OG || c == "E" ||
             c == CH_E_DOT || c == CH_E_OG;
   endfunction

   function automatic logic back_vowel(input logic [7:0] c);
      return c == "A" || c == CH_A_OG || c == "O" || c == "U" ||
             c == CH_U_OG || c == CH_U_MAC;
   endfunction

   function automatic logic [5:0] cons_code(input logic [7:0] c);
      case (c)
         "B":      return 6'd15;
         "C":      return 6'd16;
         "D":      return 6'd17;
         "F":      return 6'd18;
         "G":      return 6'd19;
         "H":      return 6'd20;
         "K":      return 6'd21;
         "L":      return 6'd22;
         "M":      return 6'd23;
         "N":      return 6'd24;
         "P":      return 6'd25;
         "R":      return 6'd26;
         "S":      return 6'd27;
         "T":      return 6'd28;
         "V":      return 6'd29;
         "Z":      return 6'd30;
         "J":      return TOK_J_SOFT;
         CH_C_CAR: return 6'd32;
         CH_S_CAR: return 6'd33;
         CH_Z_CAR: return 6'd34;
         default:  return TOK_NONE;
      endcase
   endfunction

   // devoiced form at the end of a word
   function automatic logic [5:0] cons_final(input logic [7:0] c);
      case (c)
         "B":      return 6'd25;
         "D":      return 6'd28;
         "G":      return 6'd21;
         "Z":      return 6'd27;
         CH_Z_CAR: return 6'd33;
         default:  return cons_code(c);
      endcase
   endfunction

   function automatic logic [5:0] coda_code(input logic [7:0] c);
      case (c)
         "L":     return TOK_CODA_L;
         "M":     return TOK_CODA_M;
         "N":     return TOK_CODA_N;
         "R":     return TOK_CODA_R;
         default: return TOK_NONE;
      endcase
   endfunction

   // token of letter c between neighbors p (before) and q (after)
   function automatic dec_type g2p_decide(input logic [7:0] c, input logic pv,
                                          input logic [7:0] p, input logic qv,
                                          input logic [7:0] q);
      logic       pvow;
      logic [3:0] v;
      logic [5:0] t;
      dec_type    r;
      r    = '0;
      pvow = pv && (vowel_code(p) != 4'd0);
      v    = vowel_code(c);
      t    = qv ? cons_code(c) : cons_final(c);
      if (c == "I" && !pvow && qv && back_vowel(q)) begin
         r.hit = 1'b0;
      end else if (pvow && c == "I") begin
         r.hit = 1'b1;
         r.tok.phoneme = TOK_GLIDE_J;
      end else if (pvow && c == "U") begin
         r.hit = 1'b1;
         r.tok.phoneme = TOK_GLIDE_W;
      end else if (v != 4'd0) begin
         r.hit = 1'b1;
         r.tok.phoneme = 6'(v);
      end else if (pvow && (!qv || vowel_code(q) == 4'd0) && coda_code(c) != TOK_NONE) begin
         r.hit = 1'b1;
         r.tok.phoneme = coda_code(c);
      end else if (t != TOK_NONE) begin
         r.hit = 1'b1;
         r.tok.phoneme  = t;
         r.tok.softened = qv && front_vowel(q) && (t != TOK_J_SOFT);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/grapheme_to_phoneme_mapper.sv @@
// tokens pass the record queue, then the back end's token register, before they are shown; a
// letter's token rides with the next letter's transfer (or its own at word end); throughput:
// one letter per cycle in unless full, one token per cycle out when popped; up to 3 tokens
// per letter are buffered in a QUEUE_DEPTH record queue, so the token output rate sets the
// long-run pace; reset: synchronous, clears word context, queue pointers and the output stage
`default_nettype none

module grapheme_to_phoneme_mapper import g2p_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_letter,
   input  wire logic       req_word_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [5:0]      rsp_phoneme,
   output logic            rsp_softened,
   output logic            rsp_word_done
);

   logic    q_full;
   logic    q_empty;
   logic    wr_en;
   logic    rd_en;
   logic    accept;
   rec_type wr_data;
   rec_type rd_data;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   g2p_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .letter   (req_letter),
      .word_end (req_word_end),
      .wr_en    (wr_en),
      .wr_data  (wr_data)
   );

   g2p_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_data (rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   g2p_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rd_data       (rd_data),
      .q_empty       (q_empty),
      .rd_en         (rd_en),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_phoneme   (rsp_phoneme),
      .rsp_softened  (rsp_softened),
      .rsp_word_done (rsp_word_done)
   );

endmodule

`default_nettype wire

@@ hw/rtl/g2p_front.sv @@
// front end: letter context registers and per-letter token record build
`default_nettype none

module g2p_front import g2p_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] letter,
   input  wire logic       word_end,
   output logic            wr_en,
   output rec_type         wr_data
);

   logic [7:0] before_letter_ff, before_letter_in;
   logic       before_valid_ff, before_valid_in;
   logic [7:0] held_letter_ff, held_letter_in;
   logic       held_valid_ff, held_valid_in;

   logic       pv_new;
   logic [7:0] pl_new;
   dec_type    dec_held, dec_cur;
   logic       [3:0] cand_v;
   tok_type    [3:0] cand_t;
   logic       [2:0] k;

   always_comb begin
      pv_new   = held_valid_ff;
      pl_new   = held_valid_ff ? held_letter_ff : 8'h00;
      dec_held = g2p_decide(held_letter_ff, before_valid_ff, before_letter_ff, 1'b1, letter);
      dec_cur  = g2p_decide(letter, pv_new, pl_new, 1'b0, 8'h00);

      // opening boundary, held letter, last letter, closing boundary
      cand_v[0] = !held_valid_ff;
      cand_t[0] = '{phoneme: TOK_BOUNDARY, softened: 1'b0, word_done: 1'b0};
      cand_v[1] = held_valid_ff && dec_held.hit;
      cand_t[1] = dec_held.tok;
      cand_v[2] = word_end && dec_cur.hit;
      cand_t[2] = dec_cur.tok;
      cand_v[3] = word_end;
      cand_t[3] = '{phoneme: TOK_BOUNDARY, softened: 1'b0, word_done: 1'b1};

      // at most three candidates are ever set; pack them in order
      wr_data = '0;
      k = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            wr_data.toks[k[1:0]] = cand_t[i];
            k = k + 3'd1;
         end
      end
      wr_data.cnt = k[1:0];
      wr_en = accept && (k != 3'd0);

      before_letter_in = before_letter_ff;
      before_valid_in  = before_valid_ff;
      held_letter_in   = held_letter_ff;
      held_valid_in    = held_valid_ff;
      if (accept) begin
         if (word_end) begin
            before_letter_in = 8'h00;
            before_valid_in  = 1'b0;
            held_letter_in   = 8'h00;
            held_valid_in    = 1'b0;
         end else begin
            before_letter_in = pl_new;
            before_valid_in  = pv_new;
            held_letter_in   = letter;
            held_valid_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         before_letter_ff <= 8'h00;
         before_valid_ff  <= 1'b0;
         held_letter_ff   <= 8'h00;
         held_valid_ff    <= 1'b0;
      end else begin
         before_letter_ff <= before_letter_in;
         before_valid_ff  <= before_valid_in;
         held_letter_ff   <= held_letter_in;
         held_valid_ff    <= held_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/g2p_queue.sv @@
// record queue between the front and back ends
`default_nettype none
`include "grapheme_to_phoneme_mapper_defines.svh"

module g2p_queue import g2p_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  rec_type      wr_data,
   input  wire logic    rd_en,
   output rec_type      rd_data,
   output logic         full,
   output logic         empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rec_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `G2P_ASSERT_NOW(a_no_overflow, clock, reset, wr_en, !full)
   `G2P_ASSERT_NOW(a_no_underflow, clock, reset, rd_en, !empty)
   `G2P_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ hw/rtl/g2p_back.sv @@
// back end: unpacks token records one token per transfer
`default_nettype none
`include "grapheme_to_phoneme_mapper_defines.svh"

module g2p_back import g2p_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  rec_type         rd_data,
   input  wire logic       q_empty,
   output logic            rd_en,
   input  wire logic       rsp_pop,
   output logic            rsp_empty,
   output logic [5:0]      rsp_phoneme,
   output logic            rsp_softened,
   output logic            rsp_word_done
);

   rec_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;

   logic       last_tok;
   logic       advance;
   tok_type    tok;

   always_comb begin
      last_tok = valid_ff && (idx_ff == 2'(cur_ff.cnt - 2'd1));
      advance  = !valid_ff || (rsp_pop && last_tok);
      rd_en    = advance && !q_empty;

      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (rd_en) begin
         cur_in   = rd_data;
         idx_in   = 2'd0;
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else if (rsp_pop) begin
         idx_in = idx_ff + 2'd1;
      end

      tok           = cur_ff.toks[idx_ff];
      rsp_empty     = !valid_ff;
      rsp_phoneme   = tok.phoneme;
      rsp_softened  = tok.softened;
      rsp_word_done = tok.word_done;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `G2P_ASSERT_NOW(a_idx_in_record, clock, reset, valid_ff, idx_ff < cur_ff.cnt)
   `G2P_ASSERT_NOW(a_done_is_boundary, clock, reset, valid_ff && rsp_word_done, rsp_phoneme == TOK_BOUNDARY && !rsp_softened)
   `G2P_ASSERT_NEXT(a_held_token_stable, clock, reset, valid_ff && !rsp_pop, valid_ff && $stable(idx_ff))

endmodule

`default_nettype wire

@@ tb/phoneme_checker.sv @@
// scoreboard that predicts the mapper's phoneme tokens and checks every token transfer
`timescale 1ns / 100ps

module phoneme_checker import g2p_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_letter,
   input  logic       req_word_end,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [5:0] rsp_phoneme,
   input  logic       rsp_softened,
   input  logic       rsp_word_done,
   output int         failures,
   output int         outstanding
);

   // PH_BOUND doubles as "no token" in the letter classifiers below
   typedef enum logic [5:0] {
      PH_BOUND, PH_AA, PH_EA, PH_EE, PH_I, PH_II, PH_OO, PH_U, PH_UU, PH_J, PH_W,
      PH_CODA_L, PH_CODA_M, PH_CODA_N, PH_CODA_R,
      PH_B, PH_TS, PH_D, PH_F, PH_G, PH_H, PH_K, PH_L, PH_M, PH_N, PH_P, PH_R,
      PH_S, PH_T, PH_V, PH_Z, PH_JS, PH_TSH, PH_SH, PH_ZH
   } phone_type;

   typedef struct packed {
      logic [5:0] phoneme;
      logic       softened;
      logic       word_done;
   } phone_tok_type;

   phone_tok_type tokens_due[$];
   phone_tok_type want;
   logic [7:0] prev_ch;
   logic       prev_ok;
   logic [7:0] hold_ch;
   logic       hold_ok;
   int         fail_count = 0;

   assign failures = fail_count;

   function automatic phone_type vowel_id(input logic [7:0] c);
      case (c)
         "A", CH_A_OG:      return PH_AA;
         "E", CH_E_OG:      return PH_EA;
         CH_E_DOT:          return PH_EE;
         "I":               return PH_I;
         "Y", CH_I_OG:      return PH_II;
         "O":               return PH_OO;
         "U":               return PH_U;
         CH_U_OG, CH_U_MAC: return PH_UU;
         default:           return PH_BOUND;
      endcase
   endfunction

   function automatic logic is_front(input logic [7:0] c);
      return c inside {"I", "Y", "E", CH_I_OG, CH_E_DOT, CH_E_OG};
   endfunction

   function automatic logic is_back(input logic [7:0] c);
      return c inside {"A", "O", "U", CH_A_OG, CH_U_OG, CH_U_MAC};
   endfunction

   function automatic phone_type plain_cons(input logic [7:0] c);
      case (c)
         "B":      return PH_B;
         "C":      return PH_TS;
         "D":      return PH_D;
         "F":      return PH_F;
         "G":      return PH_G;
         "H":      return PH_H;
         "K":      return PH_K;
         "L":      return PH_L;
         "M":      return PH_M;
         "N":      return PH_N;
         "P":      return PH_P;
         "R":      return PH_R;
         "S":      return PH_S;
         "T":      return PH_T;
         "V":      return PH_V;
         "Z":      return PH_Z;
         "J":      return PH_JS;
         CH_C_CAR: return PH_TSH;
         CH_S_CAR: return PH_SH;
         CH_Z_CAR: return PH_ZH;
         default:  return PH_BOUND;
      endcase
   endfunction

   function automatic phone_type devoiced_cons(input logic [7:0] c);
      case (c)
         "B":      return PH_P;
         "D":      return PH_T;
         "G":      return PH_K;
         "Z":      return PH_S;
         CH_Z_CAR: return PH_SH;
         default:  return plain_cons(c);
      endcase
   endfunction

   function automatic phone_type coda_of(input logic [7:0] c);
      case (c)
         "L":     return PH_CODA_L;
         "M":     return PH_CODA_M;
         "N":     return PH_CODA_N;
         "R":     return PH_CODA_R;
         default: return PH_BOUND;
      endcase
   endfunction

   task automatic add_token(input logic [5:0] ph, input logic sf, input logic dn);
      tokens_due.push_back('{phoneme: ph, softened: sf, word_done: dn});
   endtask

   // token of letter c between neighbors p (before) and q (after), if it has one
   task automatic letter_token(input logic [7:0] c, input logic pv, input logic [7:0] p,
                               input logic qv, input logic [7:0] q);
      logic      after_vowel;
      phone_type vc;
      phone_type cd;
      phone_type t;
      after_vowel = pv && vowel_id(p) != PH_BOUND;
      vc = vowel_id(c);
      cd = coda_of(c);
      t = qv ? plain_cons(c) : devoiced_cons(c);
      // i merges into a following back vowel
      if (c == "I" && !after_vowel && qv && is_back(q)) begin
         return;
      end
      if (after_vowel && c == "I") begin
         add_token(PH_J, 1'b0, 1'b0);
      end else if (after_vowel && c == "U") begin
         add_token(PH_W, 1'b0, 1'b0);
      end else if (vc != PH_BOUND) begin
         add_token(vc, 1'b0, 1'b0);
      end else if (after_vowel && (!qv || vowel_id(q) == PH_BOUND) && cd != PH_BOUND) begin
         add_token(cd, 1'b0, 1'b0);
      end else if (t != PH_BOUND) begin
         add_token(t, qv && is_front(q) && t != PH_JS, 1'b0);
      end
   endtask

   task automatic clear_word();
      prev_ch = '0;
      prev_ok = 1'b0;
      hold_ch = '0;
      hold_ok = 1'b0;
   endtask

   task automatic map_letter(input logic [7:0] x, input logic last);
      if (!hold_ok) begin
         add_token(PH_BOUND, 1'b0, 1'b0);
         prev_ch = '0;
         prev_ok = 1'b0;
      end else begin
         letter_token(hold_ch, prev_ok, prev_ch, 1'b1, x);
         prev_ch = hold_ch;
         prev_ok = 1'b1;
      end
      hold_ch = x;
      hold_ok = 1'b1;
      if (last) begin
         letter_token(x, prev_ok, prev_ch, 1'b0, 8'h00);
         add_token(PH_BOUND, 1'b0, 1'b1);
         clear_word();
      end
   endtask

   task automatic report(input string what);
      $display("token mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_word();
         tokens_due.delete();
      end else begin
         // drain before predicting: a letter's tokens never leave in its own transfer cycle
         if (rsp_pop && !rsp_empty) begin
            if (tokens_due.size() == 0) begin
               report($sformatf("token %0d with nothing expected", rsp_phoneme));
            end else begin
               want = tokens_due.pop_front();
               if (rsp_phoneme !== want.phoneme)
                  report($sformatf("phoneme expected %0d got %0d", want.phoneme, rsp_phoneme));
               if (rsp_softened !== want.softened)
                  report($sformatf("softened expected %0b got %0b on phoneme %0d",
                                   want.softened, rsp_softened, want.phoneme));
               if (rsp_word_done !== want.word_done)
                  report($sformatf("word_done expected %0b got %0b on phoneme %0d",
                                   want.word_done, rsp_word_done, want.phoneme));
            end
         end
         if (req_push && !req_full)
            map_letter(req_letter, req_word_end);
      end
      outstanding <= tokens_due.size();
   end

endmodule

@@ tb/testbench.sv @@
// top of the phoneme mapper regression: clock, reset, letter stimulus and verdict
`timescale 1ns / 100ps

module testbench;
   import g2p_pkg::*;

   localparam int RANDOM_ITEMS = 480;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {POP_ALWAYS, POP_HALF, POP_QUARTER, POP_MASK} pop_mode_type;

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       req_push     = 1'b0;
   logic       req_full;
   logic [7:0] req_letter   = '0;
   logic       req_word_end = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop      = 1'b0;
   logic [5:0] rsp_phoneme;
   logic       rsp_softened;
   logic       rsp_word_done;

   int           failures;
   int           outstanding;
   int           cycle_count  = 0;
   int           burst_left   = 0;
   int           letters_sent = 0;
   pop_mode_type pop_mode     = POP_ALWAYS;
   logic [7:0]   pop_mask     = '1;

   logic [7:0] vowel_pool [13] = '{"A", "E", "I", "I", "O", "U", "Y",
                                   CH_A_OG, CH_E_OG, CH_E_DOT, CH_I_OG, CH_U_OG, CH_U_MAC};
   // q, w and x are not part of the alphabet; the block gives them no token, but they still count as neighbors
   logic [7:0] consonant_pool [23] = '{"B", "C", "D", "F", "G", "H", "J", "K", "L", "M",
                                       "N", "P", "R", "S", "T", "V", "Z", "Q", "W", "X",
                                       CH_C_CAR, CH_S_CAR, CH_Z_CAR};

   grapheme_to_phoneme_mapper dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_letter    (req_letter),
      .req_word_end  (req_word_end),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_phoneme   (rsp_phoneme),
      .rsp_softened  (rsp_softened),
      .rsp_word_done (rsp_word_done)
   );

   phoneme_checker token_watch (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_letter    (req_letter),
      .req_word_end  (req_word_end),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_phoneme   (rsp_phoneme),
      .rsp_softened  (rsp_softened),
      .rsp_word_done (rsp_word_done),
      .failures      (failures),
      .outstanding   (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stalls on its own schedule, and switches its stall style at random
   always @(posedge clock) begin
      if (cycle_count % 97 == 0) begin
         pop_mode <= pop_mode_type'($urandom_range(0, 3));
         pop_mask <= 8'($urandom);
      end
      case (pop_mode)
         POP_ALWAYS:  rsp_pop <= 1'b1;
         POP_HALF:    rsp_pop <= 1'($urandom_range(0, 1));
         POP_QUARTER: rsp_pop <= ($urandom_range(0, 3) == 0);
         default:     rsp_pop <= pop_mask[3'(cycle_count % 8)];
      endcase
   end

   // one letter transfer; a fresh burst may open with an idle gap
   task automatic send(input logic [7:0] ch, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_push     <= 1'b1;
      req_letter   <= ch;
      req_word_end <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_left--;
      letters_sent++;
   endtask

   task automatic send_word(input string w);
      for (int i = 0; i < w.len(); i++)
         send(w[i], i == w.len() - 1);
   endtask

   task automatic send_random_word();
      int         len;
      int         pick;
      logic [7:0] ch;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            ch = 8'($urandom_range(0, 255));
         else if (pick < 55)
            ch = vowel_pool[4'($urandom_range(0, 12))];
         else
            ch = consonant_pool[5'($urandom_range(0, 22))];
         send(ch, i == len - 1);
      end
   endtask

   initial begin
      int first_random;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single-letter words, vowel and devoiced consonant
      send_word("A");
      send_word("B");
      // i swallowed before a back vowel, then glides after vowels
      send_word("IA");
      send_word("AUI");
      // coda r, then n softened before e
      send_word("ARNE");
      send_word("ON");
      // j keeps its own mark before a front vowel
      send_word("JE");
      send_word("GAZ");
      // unknown bytes at both extremes
      send(8'h00, 1'b0);
      send(8'hff, 1'b1);
      send(CH_S_CAR, 1'b0);
      send("I", 1'b1);
      send("A", 1'b0);
      send(CH_Z_CAR, 1'b1);

      first_random = letters_sent;
      while (letters_sent - first_random < RANDOM_ITEMS)
         send_random_word();
      req_push <= 1'b0;

      @(posedge clock);
      // wait until every expected token is seen and nothing extra is left waiting
      while (outstanding != 0 || !rsp_empty) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/g2p_pkg.sv
hw/rtl/g2p_front.sv
hw/rtl/g2p_queue.sv
hw/rtl/g2p_back.sv
hw/rtl/grapheme_to_phoneme_mapper.sv
tb/phoneme_checker.sv
tb/testbench.sv
